// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the scanner RTL.
// Each takes a label, the clock, the active-low reset, the property parts and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Hold an implication that reaches into the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- rtl/msls_pkg.sv -----
// Package for the multi-signature line scanner.
// Holds the signature table, history and result types; depends on nothing.
package msls_pkg;

    localparam int HIST_DEPTH = 13;
    localparam int SIG_NUM    = 10;
    localparam int SIG_W      = 8 * (HIST_DEPTH + 1);
    localparam int LINE_W     = 24;
    localparam int MASK_W     = 10;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] NUL_CHAR     = 8'h00;

    typedef logic [7:0]                   byte_t;
    typedef logic [HIST_DEPTH-1:0][7:0]   hist_t;
    typedef logic [SIG_W-1:0]             sig_text_t;
    typedef logic [SIG_NUM-1:0]           sig_mask_t;

    // Right-aligned: last character in the low byte.
    localparam sig_text_t SIG_TEXT [SIG_NUM] = '{
        "eval(", "system(", "exec(", "rm -rf", "wget",
        "curl", {"base64_", "decode("}, "<script>", "<?php", "DROP TABLE"
    };

    localparam int SIG_LEN [SIG_NUM] = '{5, 7, 5, 6, 4, 4, 14, 8, 5, 10};

    typedef struct packed {
        logic [LINE_W-1:0] line_no;
        logic [MASK_W-1:0] match_mask;
        logic              file_hit;
        logic              file_done;
    } result_t;

    function automatic logic sig_hit(input int idx, input byte_t cur, input hist_t hist);
        logic hit;
        hit = (cur == SIG_TEXT[idx][7:0]);
        for (int k = 1; k <= HIST_DEPTH; k++)
        begin
            if (k < SIG_LEN[idx])
            begin
                hit = hit & (hist[k-1] == SIG_TEXT[idx][8*k +: 8]);
            end
        end
        return hit;
    endfunction

endpackage

// ----- rtl/multi_signature_line_scanner.sv -----
// Multi-signature line scanner, top level.
// Depends on msls_pkg, msls_matcher, msls_line_ctrl, msls_out_stage, assert_macros.svh.
//
// Usage:
//   Slave side takes one file byte per beat: s_tdata is the byte, s_tlast marks
//   the file's final byte. Master side gives one beat per line end: line number
//   and match mask in m_tdata, sticky file hit in m_tuser, and m_tlast on the
//   result for the file's last line. Bytes that do not end a line give no beat.
//   A line-ending byte's result is loaded into the output register when the byte
//   is accepted. Throughput: one byte per cycle while s_tready is high; the byte
//   history and SIGNATURE_COUNT comparators settle within the accepting cycle.
//   A line closes at a newline, at the file's last byte, or after CHUNK_BYTES
//   bytes without a newline. After the last byte all line and file state
//   returns to its reset value, so the next byte opens a new file at line 1.
//   Reset clears the history, counters and the output register's valid flag.
//   Stall: a held result stays on m_tdata while m_tready is low; s_tready
//   stays high while the output register is empty or is being taken.
module multi_signature_line_scanner #(
    parameter int CHUNK_BYTES     = 1023,
    parameter int SIGNATURE_COUNT = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [23:0] line_no, [33:24] match_mask, [39:34] zero
    output logic        m_tuser,   // [0] file_hit
    output logic        m_tlast    // file_done
);
    import msls_pkg::*;

    `include "assert_macros.svh"

    logic      accept;
    logic      line_end;
    sig_mask_t hits;
    result_t   result;
    result_t   held;

    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    msls_matcher #(
        .SIGNATURE_COUNT(SIGNATURE_COUNT)
    ) u_matcher (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .clear     (accept && line_end),
        .data_byte (s_tdata),
        .hits      (hits)
    );

    msls_line_ctrl #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_line_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .data_byte   (s_tdata),
        .end_of_file (s_tlast),
        .hits        (hits),
        .line_end    (line_end),
        .result      (result)
    );

    msls_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept && line_end),
        .result (result),
        .take   (m_tready),
        .valid  (m_tvalid),
        .held   (held)
    );

    assign m_tdata = {6'b0, held.match_mask, held.line_no};
    assign m_tuser = held.file_hit;
    assign m_tlast = held.file_done;

    `ASSERT_ALWAYS(a_line_nonzero, clk, rst_n, !m_tvalid || (m_tdata[23:0] != 24'd0),
        "result line number is zero")
    `ASSERT_ALWAYS(a_mask_implies_hit, clk, rst_n,
        !m_tvalid || (m_tdata[33:24] == 10'd0) || m_tuser,
        "line match without file hit")
    `ASSERT_NEXT(a_eof_result, clk, rst_n, s_tvalid && s_tready && s_tlast,
        m_tvalid && m_tlast, "last byte did not produce a final result")

endmodule

// ----- rtl/msls_matcher.sv -----
// Byte history shift line and parallel signature comparators.
// Depends on msls_pkg.
module msls_matcher #(
    parameter int SIGNATURE_COUNT = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               clear,
    input  msls_pkg::byte_t    data_byte,
    output msls_pkg::sig_mask_t hits
);
    import msls_pkg::*;

    hist_t hist_reg;
    hist_t hist_next;

    always_comb
    begin
        hist_next = hist_reg;
        if (clear)
        begin
            hist_next = '0;
        end
        else if (advance)
        begin
            hist_next = {hist_reg[HIST_DEPTH-2:0], data_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    for (genvar s = 0; s < SIG_NUM; s++)
    begin : g_sig
        if (s < SIGNATURE_COUNT)
        begin : g_on
            assign hits[s] = sig_hit(s, data_byte, hist_reg);
        end
        else
        begin : g_off
            assign hits[s] = 1'b0;
        end
    end

endmodule

// ----- rtl/msls_line_ctrl.sv -----
// Line tracking: chunk length, NUL gating, line mask, line count, file hit.
// Depends on msls_pkg.
module msls_line_ctrl #(
    parameter int CHUNK_BYTES = 1023
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  msls_pkg::byte_t     data_byte,
    input  logic                end_of_file,
    input  msls_pkg::sig_mask_t hits,
    output logic                line_end,
    output msls_pkg::result_t   result
);
    import msls_pkg::*;

    localparam int CHUNK_W = $clog2(CHUNK_BYTES);

    logic [CHUNK_W-1:0] chunk_reg,  chunk_next;
    logic [MASK_W-1:0]  mask_reg,   mask_next;
    logic [LINE_W-1:0]  line_reg,   line_next;
    logic               nul_reg,    nul_next;
    logic               sticky_reg, sticky_next;

    logic               nul_now;
    logic [MASK_W-1:0]  mask_now;
    logic               sticky_now;
    logic [LINE_W-1:0]  line_inc;

    always_comb
    begin
        nul_now    = nul_reg | (data_byte == NUL_CHAR);
        mask_now   = nul_now ? mask_reg : (mask_reg | MASK_W'(hits));
        sticky_now = sticky_reg | (mask_now != '0);
        line_inc   = (line_reg == '1) ? line_reg : line_reg + 1'b1;
        line_end   = end_of_file || (data_byte == NEWLINE_CHAR)
                     || (chunk_reg == CHUNK_W'(CHUNK_BYTES - 1));

        result.line_no     = line_inc;
        result.match_mask  = mask_now;
        result.file_hit    = sticky_now;
        result.file_done   = end_of_file;

        chunk_next  = chunk_reg;
        mask_next   = mask_reg;
        line_next   = line_reg;
        nul_next    = nul_reg;
        sticky_next = sticky_reg;
        if (advance)
        begin
            if (line_end)
            begin
                chunk_next  = '0;
                mask_next   = '0;
                nul_next    = 1'b0;
                line_next   = end_of_file ? '0 : line_inc;
                sticky_next = end_of_file ? 1'b0 : sticky_now;
            end
            else
            begin
                chunk_next  = chunk_reg + 1'b1;
                mask_next   = mask_now;
                nul_next    = nul_now;
                sticky_next = sticky_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg  <= '0;
            mask_reg   <= '0;
            line_reg   <= '0;
            nul_reg    <= 1'b0;
            sticky_reg <= 1'b0;
        end
        else
        begin
            chunk_reg  <= chunk_next;
            mask_reg   <= mask_next;
            line_reg   <= line_next;
            nul_reg    <= nul_next;
            sticky_reg <= sticky_next;
        end
    end

endmodule

// ----- rtl/msls_out_stage.sv -----
// Output register holding one result beat for the master side.
// Depends on msls_pkg.
module msls_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  msls_pkg::result_t result,
    input  logic              take,
    output logic              valid,
    output msls_pkg::result_t held
);
    import msls_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign valid = valid_reg;
    assign held  = data_reg;

endmodule
